// ===== src/ilp_pkg.sv =====
// Shared types, constants and helper functions for the INI line parser.
// No dependencies; the files that use it refer to this package by scoped names.
`timescale 1ns / 1ps
package ilp_pkg;

	localparam int SECTION_CAP = 16;
	localparam int KEY_CAP     = 16;
	localparam int VALUE_CAP   = 32;

	localparam int SEC_LW = $clog2(SECTION_CAP + 1);
	localparam int KEY_LW = $clog2(KEY_CAP + 1);
	localparam int VAL_LW = $clog2(VALUE_CAP + 1);
	localparam int SEC_AW = $clog2(SECTION_CAP);
	localparam int KEY_AW = $clog2(KEY_CAP);
	localparam int VAL_AW = $clog2(VALUE_CAP);
	localparam int IDX_W  = (SEC_LW > KEY_LW) ? ((SEC_LW > VAL_LW) ? SEC_LW : VAL_LW) :
		((KEY_LW > VAL_LW) ? KEY_LW : VAL_LW);

	typedef logic [SEC_LW-1:0] sec_len_t;
	typedef logic [KEY_LW-1:0] key_len_t;
	typedef logic [VAL_LW-1:0] val_len_t;
	typedef logic [IDX_W-1:0]  idx_t;
	typedef logic [5:0]        len6_t;

	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_SEMI  = 8'h3B;
	localparam logic [7:0] CH_LBRK  = 8'h5B;
	localparam logic [7:0] CH_RBRK  = 8'h5D;
	localparam logic [7:0] CH_EQ    = 8'h3D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_UZ    = 8'h5A;

	typedef enum logic [2:0] {
		KIND_SECTION = 3'd0,
		KIND_KEY     = 3'd1,
		KIND_VALUE   = 3'd2,
		KIND_REC_END = 3'd3,
		KIND_DONE    = 3'd4
	} kind_t;

	typedef enum logic [1:0] {
		SEL_SECTION = 2'd0,
		SEL_KEY     = 2'd1,
		SEL_VALUE   = 2'd2
	} store_sel_t;

	typedef struct packed {
		logic       en;
		store_sel_t sel;
		idx_t       addr;
		logic [7:0] data;
	} store_wr_t;

	typedef struct packed {
		logic        rec;
		logic        done;
		sec_len_t    sec_len;
		key_len_t    key_len;
		val_len_t    val_len;
		logic [15:0] bad;
	} job_t;

	typedef struct packed {
		logic  we;
		len6_t raw;
		len6_t trim;
	} acc_t;

	function automatic logic is_ws(input logic [7:0] c);
		return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR);
	endfunction

	function automatic logic [7:0] to_lower(input logic [7:0] c);
		return (c >= CH_UA && c <= CH_UZ) ? (c + 8'h20) : c;
	endfunction

	function automatic logic [15:0] sat_inc(input logic [15:0] v);
		return (v == 16'hFFFF) ? v : v + 16'd1;
	endfunction

	// Append one character to a trimmed field; trim reaching cap marks overflow.
	function automatic acc_t accum(input len6_t raw, input len6_t trim, input len6_t cap,
		input logic sp);
		acc_t r;
		r.we   = 1'b0;
		r.raw  = raw;
		r.trim = trim;
		if (!(raw == 6'd0 && sp) && trim < cap) begin
			r.we = raw < cap;
			if (!sp) begin
				if (raw + 6'd1 >= cap) begin
					r.trim = cap;
				end else begin
					r.trim = raw + 6'd1;
					r.raw  = raw + 6'd1;
				end
			end else if (raw < cap) begin
				r.raw = raw + 6'd1;
			end
		end
		return r;
	endfunction

endpackage

// ===== src/ilp_char_if.sv =====
// Channel interfaces: input characters and output results.
// Depends on nothing beyond the clocking of the instantiating module.
`timescale 1ns / 1ps
interface ilp_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] text_char;
	logic       end_of_text;
	modport source (output valid, output text_char, output end_of_text, input ready);
	modport sink (input valid, input text_char, input end_of_text, output ready);
endinterface

interface ilp_res_if;
	logic        valid;
	logic        ready;
	logic [2:0]  kind;
	logic [7:0]  out_char;
	logic [15:0] bad_lines_so_far;
	logic        run_end;
	modport source (output valid, output kind, output out_char, output bad_lines_so_far,
		output run_end, input ready);
	modport sink (input valid, input kind, input out_char, input bad_lines_so_far,
		input run_end, output ready);
endinterface

// ===== src/ilp_front.sv =====
// Front end: accepts characters, tracks the line phase and field lengths,
// issues store writes and queues emit jobs. Uses ilp_pkg and ilp_char_if.
`timescale 1ns / 1ps
module ilp_front (
	input  logic               clk,
	input  logic               arst_n,
	ilp_char_if.sink           text,
	input  logic               stall,
	output ilp_pkg::store_wr_t wr,
	output logic               push,
	output ilp_pkg::job_t      job
);

	typedef enum logic [4:0] {
		PH_START   = 5'b00001,
		PH_SKIP    = 5'b00010,
		PH_SECTION = 5'b00100,
		PH_KEY     = 5'b01000,
		PH_VALUE   = 5'b10000
	} phase_t;

	phase_t            phase_q, n_phase;
	ilp_pkg::sec_len_t sec_len_q, sec_raw_q;
	ilp_pkg::key_len_t key_trim_q, key_raw_q;
	ilp_pkg::val_len_t val_trim_q, val_raw_q;
	logic [15:0]       bad_q, n_bad;
	ilp_pkg::len6_t    n_sec_len, n_sec_raw, n_key_trim, n_key_raw, n_val_trim, n_val_raw;
	ilp_pkg::acc_t     acc;
	logic              accept, lf, sp, eot, rec;
	logic [7:0]        c;

	assign text.ready = !stall;
	assign accept     = text.valid && text.ready;
	assign c          = text.text_char;
	assign eot        = text.end_of_text;
	assign lf         = (c == ilp_pkg::CH_LF);
	assign sp         = ilp_pkg::is_ws(c);

	always_comb begin
		n_phase    = phase_q;
		n_bad      = bad_q;
		n_sec_len  = ilp_pkg::len6_t'(sec_len_q);
		n_sec_raw  = ilp_pkg::len6_t'(sec_raw_q);
		n_key_trim = ilp_pkg::len6_t'(key_trim_q);
		n_key_raw  = ilp_pkg::len6_t'(key_raw_q);
		n_val_trim = ilp_pkg::len6_t'(val_trim_q);
		n_val_raw  = ilp_pkg::len6_t'(val_raw_q);
		acc        = '0;
		wr         = '0;
		wr.data    = c;
		rec        = 1'b0;
		if (!lf) begin
			case (phase_q)
				PH_START: begin
					if (sp) begin
						n_phase = PH_START;
					end else if (c == ilp_pkg::CH_HASH || c == ilp_pkg::CH_SEMI) begin
						n_phase = PH_SKIP;
					end else if (c == ilp_pkg::CH_LBRK) begin
						n_sec_len = '0;
						n_sec_raw = '0;
						n_phase   = PH_SECTION;
					end else if (c == ilp_pkg::CH_EQ) begin
						n_key_trim = '0;
						n_key_raw  = '0;
						n_val_trim = '0;
						n_val_raw  = '0;
						n_phase    = PH_VALUE;
					end else begin
						acc        = ilp_pkg::accum('0, '0, 6'(ilp_pkg::KEY_CAP), 1'b0);
						n_key_trim = acc.trim;
						n_key_raw  = acc.raw;
						wr.en      = acc.we;
						wr.sel     = ilp_pkg::SEL_KEY;
						wr.data    = ilp_pkg::to_lower(c);
						n_phase    = PH_KEY;
					end
				end
				PH_SECTION: begin
					if (c == ilp_pkg::CH_RBRK) begin
						if (n_sec_len >= 6'(ilp_pkg::SECTION_CAP)) begin
							n_sec_len = '0;
							n_bad     = ilp_pkg::sat_inc(n_bad);
						end
						n_phase = PH_SKIP;
					end else begin
						acc       = ilp_pkg::accum(n_sec_raw, n_sec_len,
							6'(ilp_pkg::SECTION_CAP), sp);
						wr.en     = acc.we;
						wr.sel    = ilp_pkg::SEL_SECTION;
						wr.addr   = ilp_pkg::idx_t'(n_sec_raw);
						wr.data   = ilp_pkg::to_lower(c);
						n_sec_len = acc.trim;
						n_sec_raw = acc.raw;
					end
				end
				PH_KEY: begin
					if (c == ilp_pkg::CH_EQ) begin
						n_val_trim = '0;
						n_val_raw  = '0;
						n_phase    = PH_VALUE;
					end else begin
						acc        = ilp_pkg::accum(n_key_raw, n_key_trim,
							6'(ilp_pkg::KEY_CAP), sp);
						wr.en      = acc.we;
						wr.sel     = ilp_pkg::SEL_KEY;
						wr.addr    = ilp_pkg::idx_t'(n_key_raw);
						wr.data    = ilp_pkg::to_lower(c);
						n_key_trim = acc.trim;
						n_key_raw  = acc.raw;
					end
				end
				PH_VALUE: begin
					acc        = ilp_pkg::accum(n_val_raw, n_val_trim,
						6'(ilp_pkg::VALUE_CAP), sp);
					wr.en      = acc.we;
					wr.sel     = ilp_pkg::SEL_VALUE;
					wr.addr    = ilp_pkg::idx_t'(n_val_raw);
					n_val_trim = acc.trim;
					n_val_raw  = acc.raw;
				end
				default: begin
					n_phase = phase_q;
				end
			endcase
		end
		// line end, or end of text standing in for a missing LF
		if (lf || eot) begin
			case (n_phase)
				PH_SECTION: begin
					if (n_sec_len >= 6'(ilp_pkg::SECTION_CAP)) begin
						n_sec_len = '0;
						n_bad     = ilp_pkg::sat_inc(n_bad);
					end
				end
				PH_KEY: n_bad = ilp_pkg::sat_inc(n_bad);
				PH_VALUE: begin
					if (n_key_trim == '0 || n_key_trim >= 6'(ilp_pkg::KEY_CAP) ||
						n_val_trim >= 6'(ilp_pkg::VALUE_CAP)) begin
						n_bad = ilp_pkg::sat_inc(n_bad);
					end else begin
						rec = 1'b1;
					end
				end
				default: rec = 1'b0;
			endcase
			n_phase = PH_START;
		end
		wr.en       = wr.en && accept;
		job.rec     = rec;
		job.done    = eot;
		job.sec_len = ilp_pkg::sec_len_t'(n_sec_len);
		job.key_len = ilp_pkg::key_len_t'(n_key_trim);
		job.val_len = ilp_pkg::val_len_t'(n_val_trim);
		job.bad     = n_bad;
		push        = accept && (rec || eot);
		if (eot) begin
			n_phase   = PH_START;
			n_sec_len = '0;
			n_sec_raw = '0;
			n_bad     = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_START;
			sec_len_q  <= '0;
			sec_raw_q  <= '0;
			key_trim_q <= '0;
			key_raw_q  <= '0;
			val_trim_q <= '0;
			val_raw_q  <= '0;
			bad_q      <= '0;
		end else if (accept) begin
			phase_q    <= n_phase;
			sec_len_q  <= ilp_pkg::sec_len_t'(n_sec_len);
			sec_raw_q  <= ilp_pkg::sec_len_t'(n_sec_raw);
			key_trim_q <= ilp_pkg::key_len_t'(n_key_trim);
			key_raw_q  <= ilp_pkg::key_len_t'(n_key_raw);
			val_trim_q <= ilp_pkg::val_len_t'(n_val_trim);
			val_raw_q  <= ilp_pkg::val_len_t'(n_val_raw);
			bad_q      <= n_bad;
		end
	end

endmodule

// ===== src/ilp_job_queue.sv =====
// Two-entry queue of emit jobs between front and back.
// Uses ilp_pkg::job_t.
`timescale 1ns / 1ps
module ilp_job_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  ilp_pkg::job_t push_job,
	input  logic          pop,
	output logic          nonempty,
	output ilp_pkg::job_t head
);

	ilp_pkg::job_t slot_q [2];
	logic          wr_ptr_q, rd_ptr_q;
	logic [1:0]    count_q;

	assign nonempty = (count_q != 2'd0);
	assign head     = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

// ===== src/ilp_back.sv =====
// Back end: holds the field stores and plays out each job as result
// transactions through a registered output. Uses ilp_pkg and ilp_res_if.
`timescale 1ns / 1ps
module ilp_back (
	input  logic               clk,
	input  logic               arst_n,
	ilp_res_if.source          result,
	input  ilp_pkg::store_wr_t wr,
	input  logic               job_valid,
	input  ilp_pkg::job_t      job_in,
	output logic               pop,
	output logic               busy
);

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_SEC  = 6'b000010,
		ST_KEY  = 6'b000100,
		ST_VAL  = 6'b001000,
		ST_REND = 6'b010000,
		ST_DONE = 6'b100000
	} state_t;

	logic [7:0] sec_mem [ilp_pkg::SECTION_CAP];
	logic [7:0] key_mem [ilp_pkg::KEY_CAP];
	logic [7:0] val_mem [ilp_pkg::VALUE_CAP];

	state_t         state_q, n_state;
	ilp_pkg::job_t  job_q;
	ilp_pkg::idx_t  idx_q, n_idx;
	logic           adv, emit, n_run_end, out_valid_q;
	ilp_pkg::kind_t n_kind;

	logic [2:0]  kind_q;
	logic [7:0]  char_q;
	logic [15:0] bad_q;
	logic        run_end_q;

	assign busy                    = (state_q != ST_IDLE);
	assign adv                     = !out_valid_q || result.ready;
	assign result.valid            = out_valid_q;
	assign result.kind             = kind_q;
	assign result.out_char         = char_q;
	assign result.bad_lines_so_far = bad_q;
	assign result.run_end          = run_end_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			case (wr.sel)
				ilp_pkg::SEL_SECTION: sec_mem[wr.addr[ilp_pkg::SEC_AW-1:0]] <= wr.data;
				ilp_pkg::SEL_KEY:     key_mem[wr.addr[ilp_pkg::KEY_AW-1:0]] <= wr.data;
				ilp_pkg::SEL_VALUE:   val_mem[wr.addr[ilp_pkg::VAL_AW-1:0]] <= wr.data;
				default:              sec_mem[wr.addr[ilp_pkg::SEC_AW-1:0]] <= wr.data;
			endcase
		end
	end

	always_comb begin
		n_state   = state_q;
		n_idx     = idx_q;
		emit      = 1'b0;
		pop       = 1'b0;
		n_kind    = ilp_pkg::KIND_SECTION;
		n_run_end = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (job_valid) begin
					pop     = 1'b1;
					n_idx   = '0;
					n_state = job_in.rec ? ST_SEC : ST_DONE;
				end
			end
			ST_SEC: begin
				if (idx_q < ilp_pkg::idx_t'(job_q.sec_len)) begin
					emit   = adv;
					n_kind = ilp_pkg::KIND_SECTION;
					if (adv) n_idx = idx_q + ilp_pkg::idx_t'(1);
				end else begin
					n_idx   = '0;
					n_state = ST_KEY;
				end
			end
			ST_KEY: begin
				if (idx_q < ilp_pkg::idx_t'(job_q.key_len)) begin
					emit   = adv;
					n_kind = ilp_pkg::KIND_KEY;
					if (adv) n_idx = idx_q + ilp_pkg::idx_t'(1);
				end else begin
					n_idx   = '0;
					n_state = ST_VAL;
				end
			end
			ST_VAL: begin
				if (idx_q < ilp_pkg::idx_t'(job_q.val_len)) begin
					emit   = adv;
					n_kind = ilp_pkg::KIND_VALUE;
					if (adv) n_idx = idx_q + ilp_pkg::idx_t'(1);
				end else begin
					n_state = ST_REND;
				end
			end
			ST_REND: begin
				emit      = adv;
				n_kind    = ilp_pkg::KIND_REC_END;
				n_run_end = !job_q.done;
				if (adv) n_state = job_q.done ? ST_DONE : ST_IDLE;
			end
			ST_DONE: begin
				emit      = adv;
				n_kind    = ilp_pkg::KIND_DONE;
				n_run_end = 1'b1;
				if (adv) n_state = ST_IDLE;
			end
			default: n_state = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= n_state;
			idx_q   <= n_idx;
			if (adv) begin
				out_valid_q <= emit;
			end
		end
	end

	// output payload, store read registered here
	always_ff @(posedge clk) begin
		if (pop) begin
			job_q <= job_in;
		end
		if (emit) begin
			kind_q    <= n_kind;
			bad_q     <= job_q.bad;
			run_end_q <= n_run_end;
			case (state_q)
				ST_SEC:  char_q <= sec_mem[idx_q[ilp_pkg::SEC_AW-1:0]];
				ST_KEY:  char_q <= key_mem[idx_q[ilp_pkg::KEY_AW-1:0]];
				ST_VAL:  char_q <= val_mem[idx_q[ilp_pkg::VAL_AW-1:0]];
				default: char_q <= 8'h00;
			endcase
		end
	end

endmodule

// ===== src/ini_line_parser.sv =====
// Top level of the INI line parser: front end, job queue and back end.
// Uses ilp_pkg, ilp_char_if/ilp_res_if, ilp_front, ilp_job_queue, ilp_back.
//
// Characters are taken one per cycle while a line is being scanned. A line
// end that yields a record, or the end-of-text character, queues a job; input
// then holds off until the back end has played the job out, one result per
// cycle while the receiver is ready, from the section, key and value stores,
// with states for job handoff and field switching in between.
`timescale 1ns / 1ps
module ini_line_parser (
	input  logic      clk,
	input  logic      arst_n,
	ilp_char_if.sink  text,
	ilp_res_if.source result
);

	ilp_pkg::store_wr_t wr;
	ilp_pkg::job_t      push_job, head;
	logic               push, pop, nonempty, busy, stall;

	assign stall = nonempty || busy;

	ilp_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.text   (text),
		.stall  (stall),
		.wr     (wr),
		.push   (push),
		.job    (push_job)
	);

	ilp_job_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.nonempty (nonempty),
		.head     (head)
	);

	ilp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.result    (result),
		.wr        (wr),
		.job_valid (nonempty),
		.job_in    (head),
		.pop       (pop),
		.busy      (busy)
	);

endmodule

// ===== bench/ini_line_parser_test.sv =====
// Testbench for ini_line_parser: streams INI text, predicts every result.
// Depends on ilp_pkg, ilp_char_if / ilp_res_if and the ini_line_parser top.
`timescale 1ns / 1ps
module ini_line_parser_test;

	localparam int IDLE_LIMIT = 4000;

	typedef struct {
		logic [7:0] ch;
		logic       eot;
	} text_item_t;

	typedef struct {
		ilp_pkg::kind_t kind;
		logic [7:0]     ch;
		logic [15:0]    bad;
		logic           last;
	} parse_res_t;

	typedef enum logic [2:0] {
		LN_START, LN_SKIP, LN_SECTION, LN_KEY, LN_VALUE
	} line_state_t;

	logic clk;
	logic arst_n;

	ilp_char_if text_ch ();
	ilp_res_if  res_ch ();

	ini_line_parser dut (
		.clk    (clk),
		.arst_n (arst_n),
		.text   (text_ch),
		.result (res_ch)
	);

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	text_item_t pending_text[$];
	parse_res_t expected_res[$];
	parse_res_t step_res[$];
	int         errors;

	// shadow parser state
	line_state_t ln_state;
	logic [7:0]  sec_mem[ilp_pkg::SECTION_CAP];
	logic [7:0]  key_mem[ilp_pkg::KEY_CAP];
	logic [7:0]  val_mem[ilp_pkg::VALUE_CAP];
	logic [5:0]  sec_len, sec_raw, key_trim, key_raw, val_trim, val_raw;
	logic [15:0] bad_cnt;

	task automatic report(input string what);
		$display("mismatch at %0t: %s", $realtime, what);
		errors++;
	endtask

	function automatic logic blank(input logic [7:0] c);
		return c == ilp_pkg::CH_SPACE || c == ilp_pkg::CH_TAB || c == ilp_pkg::CH_CR;
	endfunction

	function automatic logic [7:0] lower(input logic [7:0] c);
		return (c >= 8'h41 && c <= 8'h5A) ? c + 8'h20 : c;
	endfunction

	task automatic bump_bad();
		if (bad_cnt != 16'hFFFF)
			bad_cnt++;
	endtask

	task automatic push_res(input ilp_pkg::kind_t k, input logic [7:0] c);
		parse_res_t r;
		r.kind = k;
		r.ch   = c;
		r.bad  = bad_cnt;
		r.last = 1'b0;
		step_res.push_back(r);
	endtask

	// trimmed append; trim reaching cap marks overflow
	task automatic append_field(input ilp_pkg::store_sel_t sel, input logic [7:0] c);
		logic [5:0] raw, trim, cap;
		logic       sp;
		sp = blank(c);
		case (sel)
			ilp_pkg::SEL_SECTION: begin
				raw = sec_raw; trim = sec_len; cap = 6'(ilp_pkg::SECTION_CAP);
			end
			ilp_pkg::SEL_KEY: begin
				raw = key_raw; trim = key_trim; cap = 6'(ilp_pkg::KEY_CAP);
			end
			default: begin
				raw = val_raw; trim = val_trim; cap = 6'(ilp_pkg::VALUE_CAP);
			end
		endcase
		if ((raw == 0 && sp) || trim >= cap)
			return;
		if (raw < cap) begin
			case (sel)
				ilp_pkg::SEL_SECTION: sec_mem[raw] = lower(c);
				ilp_pkg::SEL_KEY:     key_mem[raw] = lower(c);
				default:              val_mem[raw] = c;
			endcase
		end
		if (!sp && raw + 6'd1 >= cap) begin
			trim = cap;
		end else begin
			if (!sp)
				trim = raw + 6'd1;
			if (raw < cap)
				raw = raw + 6'd1;
		end
		case (sel)
			ilp_pkg::SEL_SECTION: begin
				sec_raw = raw; sec_len = trim;
			end
			ilp_pkg::SEL_KEY: begin
				key_raw = raw; key_trim = trim;
			end
			default: begin
				val_raw = raw; val_trim = trim;
			end
		endcase
	endtask

	task automatic close_sec();
		if (sec_len >= ilp_pkg::SECTION_CAP) begin
			sec_len = 0;
			bump_bad();
		end
	endtask

	task automatic end_line();
		case (ln_state)
			LN_SECTION: close_sec();
			LN_KEY: bump_bad();
			LN_VALUE: begin
				if (key_trim == 0 || key_trim >= ilp_pkg::KEY_CAP ||
					val_trim >= ilp_pkg::VALUE_CAP) begin
					bump_bad();
				end else begin
					for (int i = 0; i < sec_len; i++)
						push_res(ilp_pkg::KIND_SECTION, sec_mem[i]);
					for (int i = 0; i < key_trim; i++)
						push_res(ilp_pkg::KIND_KEY, key_mem[i]);
					for (int i = 0; i < val_trim; i++)
						push_res(ilp_pkg::KIND_VALUE, val_mem[i]);
					push_res(ilp_pkg::KIND_REC_END, 8'h00);
				end
			end
			default: ;
		endcase
		ln_state = LN_START;
	endtask

	task automatic parse_char(input logic [7:0] c, input logic eot);
		step_res.delete();
		if (c == ilp_pkg::CH_LF) begin
			end_line();
		end else begin
			case (ln_state)
				LN_START: begin
					if (!blank(c)) begin
						if (c == ilp_pkg::CH_HASH || c == ilp_pkg::CH_SEMI) begin
							ln_state = LN_SKIP;
						end else if (c == ilp_pkg::CH_LBRK) begin
							sec_len = 0; sec_raw = 0;
							ln_state = LN_SECTION;
						end else if (c == ilp_pkg::CH_EQ) begin
							key_trim = 0; key_raw = 0; val_trim = 0; val_raw = 0;
							ln_state = LN_VALUE;
						end else begin
							key_trim = 0; key_raw = 0;
							ln_state = LN_KEY;
							append_field(ilp_pkg::SEL_KEY, c);
						end
					end
				end
				LN_SECTION: begin
					if (c == ilp_pkg::CH_RBRK) begin
						close_sec();
						ln_state = LN_SKIP;
					end else begin
						append_field(ilp_pkg::SEL_SECTION, c);
					end
				end
				LN_KEY: begin
					if (c == ilp_pkg::CH_EQ) begin
						val_trim = 0; val_raw = 0;
						ln_state = LN_VALUE;
					end else begin
						append_field(ilp_pkg::SEL_KEY, c);
					end
				end
				LN_VALUE: append_field(ilp_pkg::SEL_VALUE, c);
				default: ;
			endcase
		end
		if (eot) begin
			if (c != ilp_pkg::CH_LF)
				end_line();
			push_res(ilp_pkg::KIND_DONE, 8'h00);
			ln_state = LN_START;
			sec_len = 0; sec_raw = 0;
			bad_cnt = 0;
		end
		if (step_res.size() > 0)
			step_res[step_res.size() - 1].last = 1'b1;
		foreach (step_res[i])
			expected_res.push_back(step_res[i]);
	endtask

	// ---- stimulus helpers ----
	task automatic put_str(input string s);
		text_item_t it;
		for (int i = 0; i < s.len(); i++) begin
			it.ch  = s[i];
			it.eot = 1'b0;
			pending_text.push_back(it);
		end
	endtask

	task automatic put_char(input logic [7:0] c);
		text_item_t it;
		it.ch  = c;
		it.eot = 1'b0;
		pending_text.push_back(it);
	endtask

	task automatic mark_eot();
		pending_text[pending_text.size() - 1].eot = 1'b1;
	endtask

	function automatic logic [7:0] pick_char();
		int r;
		r = $urandom_range(0, 15);
		if (r == 0)
			return $urandom_range(0, 255);
		if (r == 1)
			return ilp_pkg::CH_SPACE;
		if (r == 2)
			return ilp_pkg::CH_TAB;
		if (r == 3)
			return ilp_pkg::CH_CR;
		if (r < 8)
			return $urandom_range(8'h41, 8'h5A);
		if (r < 14)
			return $urandom_range(8'h61, 8'h7A);
		return $urandom_range(8'h30, 8'h39);
	endfunction

	// body text with no line break and no given delimiter
	task automatic put_body(input int n, input logic [7:0] avoid);
		logic [7:0] c;
		for (int i = 0; i < n; i++) begin
			c = pick_char();
			if (c == ilp_pkg::CH_LF || c == avoid)
				c = 8'h61;
			put_char(c);
		end
	endtask

	task automatic put_random_line(input logic with_lf);
		int shape;
		shape = $urandom_range(0, 19);
		put_body($urandom_range(0, 1), ilp_pkg::CH_LF);
		if (shape < 11) begin
			// key = value, sizes clustered near the caps now and then
			put_body($urandom_range(0, 3) == 0 ? $urandom_range(14, 18) : $urandom_range(0, 6),
				ilp_pkg::CH_EQ);
			put_char(ilp_pkg::CH_EQ);
			put_body($urandom_range(0, 3) == 0 ? $urandom_range(29, 35) : $urandom_range(0, 8),
				ilp_pkg::CH_LF);
		end else if (shape < 15) begin
			put_char(ilp_pkg::CH_LBRK);
			put_body($urandom_range(0, 3) == 0 ? $urandom_range(14, 18) : $urandom_range(0, 6),
				ilp_pkg::CH_RBRK);
			if ($urandom_range(0, 3) != 0)
				put_char(ilp_pkg::CH_RBRK);
			put_body($urandom_range(0, 2), ilp_pkg::CH_LF);
		end else if (shape == 15) begin
			put_char($urandom_range(0, 1) ? ilp_pkg::CH_HASH : ilp_pkg::CH_SEMI);
			put_body($urandom_range(0, 6), ilp_pkg::CH_LF);
		end else if (shape == 16) begin
			put_body($urandom_range(1, 6), ilp_pkg::CH_EQ);
		end else if (shape == 17) begin
			put_body($urandom_range(0, 10), ilp_pkg::CH_LF);
		end
		if (with_lf)
			put_char(ilp_pkg::CH_LF);
	endtask

	// ---- driver: bursts and gaps ----
	text_item_t drv_item;
	logic       took;
	int         burst_left, gap_left;

	always @(negedge clk) begin
		if (arst_n) begin
			if (!text_ch.valid || took) begin
				if (gap_left > 0 || pending_text.size() == 0) begin
					text_ch.valid <= 1'b0;
					if (gap_left > 0)
						gap_left--;
				end else begin
					drv_item = pending_text.pop_front();
					text_ch.valid       <= 1'b1;
					text_ch.text_char   <= drv_item.ch;
					text_ch.end_of_text <= drv_item.eot;
					burst_left--;
					if (burst_left <= 0) begin
						burst_left = $urandom_range(1, 40);
						gap_left   = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 6);
					end
				end
			end
		end
	end

	// ---- receiver stall pattern ----
	int rdy_mode, rdy_cnt;

	always @(negedge clk) begin
		rdy_cnt++;
		if (rdy_cnt % 128 == 0)
			rdy_mode = $urandom_range(0, 3);
		case (rdy_mode)
			0: res_ch.ready <= 1'b1;
			1: res_ch.ready <= $urandom_range(0, 1);
			2: res_ch.ready <= (rdy_cnt % 4 == 0);
			default: res_ch.ready <= ((rdy_cnt / 8) % 2 == 0);
		endcase
	end

	// ---- monitor, predictor hook and watchdog ----
	parse_res_t want;
	int         idle_cycles;

	always @(posedge clk) begin
		if (arst_n) begin
			took = text_ch.valid && text_ch.ready;
			if (took)
				parse_char(text_ch.text_char, text_ch.end_of_text);
			if (res_ch.valid && res_ch.ready) begin
				if (expected_res.size() == 0) begin
					report($sformatf("unexpected transaction kind %0d", res_ch.kind));
				end else begin
					want = expected_res.pop_front();
					if (res_ch.kind !== want.kind)
						report($sformatf("kind %0d, want %0d", res_ch.kind, want.kind));
					if (res_ch.out_char !== want.ch)
						report($sformatf("out_char %h, want %h", res_ch.out_char, want.ch));
					if (res_ch.bad_lines_so_far !== want.bad)
						report($sformatf("bad_lines_so_far %0d, want %0d",
							res_ch.bad_lines_so_far, want.bad));
					if (res_ch.run_end !== want.last)
						report($sformatf("run_end %b, want %b", res_ch.run_end, want.last));
				end
			end
			if (took || (res_ch.valid && res_ch.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
				$display("FAILURE");
				$finish;
			end
		end
	end

	initial begin
		errors      = 0;
		took        = 1'b0;
		burst_left  = 0;
		gap_left    = 0;
		idle_cycles = 0;
		rdy_mode    = 0;
		rdy_cnt     = 0;
		ln_state    = LN_START;
		sec_len = 0; sec_raw = 0; key_trim = 0; key_raw = 0; val_trim = 0; val_raw = 0;
		bad_cnt = 0;
		arst_n              = 1'b0;
		text_ch.valid       = 1'b0;
		text_ch.text_char   = 8'h00;
		text_ch.end_of_text = 1'b0;
		res_ch.ready        = 1'b0;

		// directed lines
		put_str("[Sec One]\n");
		put_str(" \t Key = Val ue \r\n");
		put_str(";c\n#c\n\n");
		put_str("[]\nk=v\n");
		put_str("[NoClose\nab=\n");
		put_str("[abc]junk\nnovalue\n=v\n");
		put_str("[abcdefghijklmnop]\nk=v\n");
		put_str("[abcdefghijklmno]\n");
		put_str("abcdefghijklmnop=x\nabcdefghijklmno=x\n");
		put_str("k=abcdefghijklmnopqrstuvwxyz012345\n");
		put_str("k=abcdefghijklmnopqrstuvwxyz01234\n");
		put_char(8'hFF); put_char(ilp_pkg::CH_EQ); put_char(8'h00); put_char(8'h80);
		put_char(ilp_pkg::CH_LF);
		put_str("last=line");
		mark_eot();
		put_str("x");
		mark_eot();
		put_str("a=b\n");
		mark_eot();

		// a couple of short random buffers of mostly well-formed lines
		for (int b = 0; b < 2; b++) begin
			int n;
			n = $urandom_range(1, 3);
			for (int l = 0; l < n; l++)
				put_random_line(l < n - 1 || $urandom_range(0, 1));
			mark_eot();
		end

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending_text.size() > 0 || text_ch.valid || expected_res.size() > 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

// ===== sim.f =====
src/ilp_pkg.sv
src/ilp_char_if.sv
src/ilp_front.sv
src/ilp_job_queue.sv
src/ilp_back.sv
src/ini_line_parser.sv
bench/ini_line_parser_test.sv
